/* rtl/core/ispp_pkg.sv */
`timescale 1ns / 1ps

package ispp_pkg;

   localparam int LINE_COUNT_WIDTH_DEF = 16;
   localparam int CHAR_WIDTH_DEF       = 8;
   localparam int QUEUE_DEPTH_DEF      = 4;

   localparam int KIND_WIDTH     = 3;
   localparam int LINE_NUM_WIDTH = 16;
   localparam int MAX_EVENTS     = 4;
   localparam int EVT_IDX_WIDTH  = $clog2(MAX_EVENTS);
   localparam int EVT_CNT_WIDTH  = $clog2(MAX_EVENTS + 1);

   localparam logic [KIND_WIDTH-1:0] KIND_CHAR    = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_SECTION = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_KEY     = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_FIRST   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_VALUE   = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_DONE    = 3'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_ERROR   = 3'd6;

   function automatic int bundle_width(input int cw);
      return EVT_CNT_WIDTH + MAX_EVENTS * (KIND_WIDTH + cw + LINE_NUM_WIDTH);
   endfunction

endpackage

/* rtl/core/ispp_if.sv */
`timescale 1ns / 1ps

interface ispp_req_if #(
   parameter int CHAR_WIDTH = ispp_pkg::CHAR_WIDTH_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_code;
   logic                  char_valid;
   logic                  end_of_text;

   modport source (output valid, output char_code, output char_valid, output end_of_text,
                   input ready);
   modport sink   (input valid, input char_code, input char_valid, input end_of_text,
                   output ready);
endinterface

interface ispp_rsp_if #(
   parameter int CHAR_WIDTH = ispp_pkg::CHAR_WIDTH_DEF
) ();
   logic                                valid;
   logic                                ready;
   logic [ispp_pkg::KIND_WIDTH-1:0]     event_kind;
   logic [CHAR_WIDTH-1:0]               string_char;
   logic [ispp_pkg::LINE_NUM_WIDTH-1:0] line_number;
   logic                                last_event;

   modport source (output valid, output event_kind, output string_char, output line_number,
                   output last_event, input ready);
   modport sink   (input valid, input event_kind, input string_char, input line_number,
                   input last_event, output ready);
endinterface

/* rtl/core/ispp_front.sv */
`timescale 1ns / 1ps

module ispp_front #(
   parameter int LINE_COUNT_WIDTH = ispp_pkg::LINE_COUNT_WIDTH_DEF,
   parameter int CHAR_WIDTH       = ispp_pkg::CHAR_WIDTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [CHAR_WIDTH-1:0]                        req_char_code,
   input  logic                                         req_char_valid,
   input  logic                                         req_end_of_text,
   output logic                                         push_valid,
   input  logic                                         push_ready,
   output logic [ispp_pkg::bundle_width(CHAR_WIDTH)-1:0] push_data
);

   localparam int CW    = CHAR_WIDTH;
   localparam int LCW   = LINE_COUNT_WIDTH;
   localparam int KW    = ispp_pkg::KIND_WIDTH;
   localparam int LNW   = ispp_pkg::LINE_NUM_WIDTH;
   localparam int ME    = ispp_pkg::MAX_EVENTS;
   localparam int IDXW  = ispp_pkg::EVT_IDX_WIDTH;
   localparam int CNTW  = ispp_pkg::EVT_CNT_WIDTH;

   localparam logic [2:0] MODE_BETWEEN = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_PSTR    = 3'd2;
   localparam logic [2:0] MODE_QSTR    = 3'd3;
   localparam logic [2:0] MODE_SLASH   = 3'd4;

   localparam logic [3:0] GS_START = 4'd1;
   localparam logic [3:0] GS_OPEN  = 4'd2;
   localparam logic [3:0] GS_NAME  = 4'd3;
   localparam logic [3:0] GS_CLOSE = 4'd4;
   localparam logic [3:0] GS_LINE  = 4'd5;
   localparam logic [3:0] GS_FIRST = 4'd6;
   localparam logic [3:0] GS_COMMA = 4'd7;
   localparam logic [3:0] GS_EQ    = 4'd8;
   localparam logic [3:0] GS_VALUE = 4'd9;

   localparam logic [2:0] TOK_EOL   = 3'd0;
   localparam logic [2:0] TOK_LBR   = 3'd1;
   localparam logic [2:0] TOK_RBR   = 3'd2;
   localparam logic [2:0] TOK_STR   = 3'd3;
   localparam logic [2:0] TOK_EQ    = 3'd4;
   localparam logic [2:0] TOK_SEP   = 3'd5;
   localparam logic [2:0] TOK_EOF   = 3'd6;
   localparam logic [2:0] TOK_ERR   = 3'd7;

   localparam logic [CW-1:0] C_TAB   = CW'(8'h09);
   localparam logic [CW-1:0] C_LF    = CW'(8'h0A);
   localparam logic [CW-1:0] C_VT    = CW'(8'h0B);
   localparam logic [CW-1:0] C_FF    = CW'(8'h0C);
   localparam logic [CW-1:0] C_CR    = CW'(8'h0D);
   localparam logic [CW-1:0] C_SUB   = CW'(8'h1A);
   localparam logic [CW-1:0] C_SP    = CW'(8'h20);
   localparam logic [CW-1:0] C_QUOTE = CW'(8'h22);
   localparam logic [CW-1:0] C_HASH  = CW'(8'h23);
   localparam logic [CW-1:0] C_COMMA = CW'(8'h2C);
   localparam logic [CW-1:0] C_SLASH = CW'(8'h2F);
   localparam logic [CW-1:0] C_SEMI  = CW'(8'h3B);
   localparam logic [CW-1:0] C_EQ    = CW'(8'h3D);
   localparam logic [CW-1:0] C_LBR   = CW'(8'h5B);
   localparam logic [CW-1:0] C_RBR   = CW'(8'h5D);

   typedef struct packed {
      logic [CNTW-1:0]          n;
      logic [ME-1:0][KW-1:0]    kind;
      logic [ME-1:0][CW-1:0]    ch;
      logic [ME-1:0][LNW-1:0]   ln;
   } bundle_type;

   typedef struct packed {
      logic [2:0]     mode;
      logic [3:0]     gst;
      logic [LCW-1:0] line;
      logic           halted;
      logic           ended;
      bundle_type     evt;
   } ctx_type;

   logic [2:0]     mode_ff,     mode_in;
   logic [3:0]     gstate_ff,   gstate_in;
   logic [LCW-1:0] line_cnt_ff, line_cnt_in;
   logic           finished_ff, finished_in;
   logic           accept;
   ctx_type        ctx_start;
   ctx_type        ctx_char;
   ctx_type        ctx_end;

   function automatic logic is_blank(input logic [CW-1:0] c);
      return c == C_SP || c == C_TAB || c == C_VT || c == C_FF || c == C_CR || c == C_SUB;
   endfunction

   function automatic logic is_plain_term(input logic [CW-1:0] c);
      return c == C_LBR || c == C_RBR || c == C_EQ || c == C_COMMA || c == C_QUOTE ||
             c == C_LF || is_blank(c);
   endfunction

   function automatic logic is_quote_term(input logic [CW-1:0] c);
      return c == C_QUOTE || c == C_LF || c == C_FF || c == C_VT || c == C_CR || c == C_SUB;
   endfunction

   function automatic ctx_type emit(input ctx_type x, input logic [KW-1:0] k,
                                    input logic [CW-1:0] c);
      ctx_type y;
      y = x;
      if (y.evt.n < CNTW'(ME)) begin
         y.evt.kind[y.evt.n[IDXW-1:0]] = k;
         y.evt.ch[y.evt.n[IDXW-1:0]]   = c;
         y.evt.ln[y.evt.n[IDXW-1:0]]   = LNW'(y.line);
         y.evt.n                       = y.evt.n + 1'b1;
      end
      return y;
   endfunction

   function automatic ctx_type gram(input ctx_type x, input logic [2:0] tok);
      ctx_type    y;
      logic       ok;
      logic       done;
      logic [3:0] nxt;
      y    = x;
      ok   = 1'b1;
      done = 1'b0;
      nxt  = x.gst;
      unique case (x.gst) inside
         GS_START, GS_LINE: begin
            if (tok == TOK_EOF) done = 1'b1;
            else if (tok == TOK_LBR) nxt = GS_OPEN;
            else if (tok == TOK_STR && x.gst == GS_LINE) nxt = GS_FIRST;
            else if (tok != TOK_EOL) ok = 1'b0;
         end
         GS_OPEN: begin
            if (tok == TOK_STR) nxt = GS_NAME;
            else ok = 1'b0;
         end
         GS_NAME: begin
            if (tok == TOK_RBR) nxt = GS_CLOSE;
            else ok = 1'b0;
         end
         GS_CLOSE: begin
            if (tok == TOK_EOL) begin
               y   = emit(y, ispp_pkg::KIND_SECTION, '0);
               nxt = GS_LINE;
            end else if (tok == TOK_EOF) begin
               y    = emit(y, ispp_pkg::KIND_SECTION, '0);
               done = 1'b1;
            end else begin
               ok = 1'b0;
            end
         end
         GS_FIRST: begin
            if (tok == TOK_EOL) begin
               y   = emit(y, ispp_pkg::KIND_FIRST, '0);
               nxt = GS_LINE;
            end else if (tok == TOK_EOF) begin
               y    = emit(y, ispp_pkg::KIND_FIRST, '0);
               done = 1'b1;
            end else if (tok == TOK_SEP) begin
               y   = emit(y, ispp_pkg::KIND_FIRST, '0);
               nxt = GS_COMMA;
            end else if (tok == TOK_EQ) begin
               y   = emit(y, ispp_pkg::KIND_KEY, '0);
               nxt = GS_EQ;
            end else begin
               ok = 1'b0;
            end
         end
         GS_COMMA, GS_EQ: begin
            if (tok == TOK_STR) begin
               y   = emit(y, ispp_pkg::KIND_VALUE, '0);
               nxt = GS_VALUE;
            end else begin
               ok = 1'b0;
            end
         end
         GS_VALUE: begin
            if (tok == TOK_EOL) nxt = GS_LINE;
            else if (tok == TOK_EOF) done = 1'b1;
            else if (tok == TOK_SEP) nxt = GS_COMMA;
            else ok = 1'b0;
         end
         default: ok = 1'b0;
      endcase

      if (!ok) begin
         y        = emit(y, ispp_pkg::KIND_ERROR, '0);
         y.halted = 1'b1;
      end else if (done) begin
         y        = emit(y, ispp_pkg::KIND_DONE, '0);
         y.halted = 1'b1;
         y.ended  = 1'b1;
      end else begin
         y.gst = nxt;
         if (tok == TOK_EOL && y.line != '1) y.line = y.line + 1'b1;
      end
      return y;
   endfunction

   function automatic ctx_type lex_between(input ctx_type x, input logic [CW-1:0] c);
      ctx_type y;
      y = x;
      if (!is_blank(c)) begin
         case (c) inside
            C_SEMI, C_HASH: y.mode = MODE_COMMENT;
            C_SLASH:        y.mode = MODE_SLASH;
            C_LBR:          y = gram(y, TOK_LBR);
            C_RBR:          y = gram(y, TOK_RBR);
            C_EQ:           y = gram(y, TOK_EQ);
            C_COMMA:        y = gram(y, TOK_SEP);
            C_LF:           y = gram(y, TOK_EOL);
            C_QUOTE:        y.mode = MODE_QSTR;
            default: begin
               y      = emit(y, ispp_pkg::KIND_CHAR, c);
               y.mode = MODE_PSTR;
            end
         endcase
      end
      return y;
   endfunction

   function automatic ctx_type lex_pstr(input ctx_type x, input logic [CW-1:0] c);
      ctx_type y;
      y = x;
      if (is_plain_term(c)) begin
         y.mode = MODE_BETWEEN;
         y      = gram(y, TOK_STR);
         if (!y.halted) y = lex_between(y, c);
      end else begin
         y = emit(y, ispp_pkg::KIND_CHAR, c);
      end
      return y;
   endfunction

   function automatic ctx_type lex_char(input ctx_type x, input logic [CW-1:0] c);
      ctx_type y;
      y = x;
      unique case (x.mode)
         MODE_COMMENT: begin
            if (c == C_LF) begin
               y.mode = MODE_BETWEEN;
               y      = lex_between(y, c);
            end
         end
         MODE_PSTR: y = lex_pstr(y, c);
         MODE_QSTR: begin
            if (c == C_QUOTE) begin
               y.mode = MODE_BETWEEN;
               y      = gram(y, TOK_STR);
            end else if (is_quote_term(c)) begin
               y = gram(y, TOK_ERR);
            end else begin
               y = emit(y, ispp_pkg::KIND_CHAR, c);
            end
         end
         MODE_SLASH: begin
            if (c == C_SLASH) begin
               y.mode = MODE_COMMENT;
            end else begin
               y      = emit(y, ispp_pkg::KIND_CHAR, C_SLASH);
               y.mode = MODE_PSTR;
               y      = lex_pstr(y, c);
            end
         end
         default: begin
            y.mode = MODE_BETWEEN;
            y      = lex_between(y, c);
         end
      endcase
      return y;
   endfunction

   function automatic ctx_type lex_eof(input ctx_type x);
      ctx_type y;
      y = x;
      unique case (x.mode)
         MODE_SLASH: begin
            y      = emit(y, ispp_pkg::KIND_CHAR, C_SLASH);
            y.mode = MODE_BETWEEN;
            y      = gram(y, TOK_STR);
         end
         MODE_PSTR: begin
            y.mode = MODE_BETWEEN;
            y      = gram(y, TOK_STR);
         end
         MODE_QSTR: y = gram(y, TOK_ERR);
         default: ;
      endcase
      if (!y.halted) y = gram(y, TOK_EOF);
      return y;
   endfunction

   always_comb begin
      ctx_start      = '0;
      ctx_start.mode = mode_ff;
      ctx_start.gst  = gstate_ff;
      ctx_start.line = line_cnt_ff;
      ctx_char       = req_char_valid ? lex_char(ctx_start, req_char_code) : ctx_start;
      ctx_end        = (!ctx_char.halted && req_end_of_text) ? lex_eof(ctx_char) : ctx_char;
   end

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && !finished_ff && ctx_end.evt.n != '0;
   assign push_data  = ctx_end.evt;

   always_comb begin
      mode_in     = mode_ff;
      gstate_in   = gstate_ff;
      line_cnt_in = line_cnt_ff;
      finished_in = finished_ff;
      if (accept) begin
         if (finished_ff) begin
            if (req_end_of_text) finished_in = 1'b0;
         end else if (ctx_end.halted) begin
            mode_in     = MODE_BETWEEN;
            gstate_in   = GS_START;
            line_cnt_in = LCW'(1);
            finished_in = !ctx_end.ended && !req_end_of_text;
         end else begin
            mode_in     = ctx_end.mode;
            gstate_in   = ctx_end.gst;
            line_cnt_in = ctx_end.line;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_BETWEEN;
         gstate_ff   <= GS_START;
         line_cnt_ff <= LCW'(1);
         finished_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         gstate_ff   <= gstate_in;
         line_cnt_ff <= line_cnt_in;
         finished_ff <= finished_in;
      end
   end

   a_discard_from_reset_state: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> (gstate_ff == GS_START && mode_ff == MODE_BETWEEN &&
                       line_cnt_ff == LCW'(1)))
      else $error("discard mode entered without parser restart");

   a_end_clears_discard: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_text) |=> !finished_ff)
      else $error("discard mode survives end of text");

endmodule

/* rtl/core/ispp_fifo.sv */
`timescale 1ns / 1ps

module ispp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ispp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill beyond depth");

endmodule

/* rtl/core/ispp_back.sv */
`timescale 1ns / 1ps

module ispp_back #(
   parameter int CHAR_WIDTH = ispp_pkg::CHAR_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          pop_valid,
   output logic                                          pop_ready,
   input  logic [ispp_pkg::bundle_width(CHAR_WIDTH)-1:0] pop_data,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic [ispp_pkg::KIND_WIDTH-1:0]               rsp_event_kind,
   output logic [CHAR_WIDTH-1:0]                         rsp_string_char,
   output logic [ispp_pkg::LINE_NUM_WIDTH-1:0]           rsp_line_number,
   output logic                                          rsp_last_event
);

   localparam int CW   = CHAR_WIDTH;
   localparam int KW   = ispp_pkg::KIND_WIDTH;
   localparam int LNW  = ispp_pkg::LINE_NUM_WIDTH;
   localparam int ME   = ispp_pkg::MAX_EVENTS;
   localparam int IDXW = ispp_pkg::EVT_IDX_WIDTH;
   localparam int CNTW = ispp_pkg::EVT_CNT_WIDTH;

   typedef struct packed {
      logic [CNTW-1:0]        n;
      logic [ME-1:0][KW-1:0]  kind;
      logic [ME-1:0][CW-1:0]  ch;
      logic [ME-1:0][LNW-1:0] ln;
   } bundle_type;

   bundle_type      head;
   logic [IDXW-1:0] idx_ff,   idx_in;
   logic            valid_ff, valid_in;
   logic [KW-1:0]   kind_ff,  kind_in;
   logic [CW-1:0]   char_ff,  char_in;
   logic [LNW-1:0]  line_ff,  line_in;
   logic            last_ff,  last_in;
   logic            load;
   logic            is_last;

   assign head      = pop_data;
   assign load      = pop_valid && (!valid_ff || rsp_ready);
   assign is_last   = CNTW'(idx_ff) == CNTW'(head.n - 1'b1);
   assign pop_ready = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      char_in  = char_ff;
      line_in  = line_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
         kind_in  = head.kind[idx_ff];
         char_in  = head.ch[idx_ff];
         line_in  = head.ln[idx_ff];
         last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      line_ff <= line_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_string_char = char_ff;
   assign rsp_line_number = line_ff;
   assign rsp_last_event  = last_ff;

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (valid_ff && last_ff))
      else $error("bundle released without its final word");

   a_index_in_bundle: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (head.n != '0 && CNTW'(idx_ff) < head.n))
      else $error("event index outside queued bundle");

endmodule

/* rtl/core/ini_section_stream_parser.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Word
// req_bus   in   valid/ready    char_code, char_valid, end_of_text
// rsp_bus   out  valid/ready    event_kind, string_char, line_number, last_event
//
// One character is taken per cycle; lexer and grammar settle a whole word in that cycle.
// A word yields zero to four result words, queued as one bundle (QUEUE_DEPTH bundles).
// Results leave at one word per cycle from a registered output stage.
// req_bus stalls only while the bundle queue is full; rsp_bus stalls hold the output register.
// Synchronous reset returns the parser to start of text with line count one.

module ini_section_stream_parser #(
   parameter int LINE_COUNT_WIDTH = ispp_pkg::LINE_COUNT_WIDTH_DEF,
   parameter int CHAR_WIDTH       = ispp_pkg::CHAR_WIDTH_DEF,
   parameter int QUEUE_DEPTH      = ispp_pkg::QUEUE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   ispp_req_if.sink    req_bus,
   ispp_rsp_if.source  rsp_bus
);

   localparam int BW = ispp_pkg::bundle_width(CHAR_WIDTH);

   logic          push_valid;
   logic          push_ready;
   logic [BW-1:0] push_data;
   logic          pop_valid;
   logic          pop_ready;
   logic [BW-1:0] pop_data;

   ispp_front #(
      .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH),
      .CHAR_WIDTH       (CHAR_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_char_code   (req_bus.char_code),
      .req_char_valid  (req_bus.char_valid),
      .req_end_of_text (req_bus.end_of_text),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   ispp_fifo #(
      .WIDTH (BW),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ispp_back #(
      .CHAR_WIDTH (CHAR_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_event_kind  (rsp_bus.event_kind),
      .rsp_string_char (rsp_bus.string_char),
      .rsp_line_number (rsp_bus.line_number),
      .rsp_last_event  (rsp_bus.last_event)
   );

endmodule
